FILE: hdl/hpvt_pkg.sv
// Shared types and constants for the homogeneous point/vector transform core.
`default_nettype none
package hpvt_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_W    = COORD_W / 2;
    localparam int SLOT_W    = 16;
    localparam int ROW_W     = 64;
    localparam int NUM_LANES = 3;
    // Rounded row sum width: product plus two carry bits, minus coefficient fraction bits.
    localparam int ROW_SUM_W = COORD_W + 6;
    localparam int QUO_W     = ROW_SUM_W + FRAC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = 2'd3;

    localparam logic [ROW_W-1:0] ROW_ZERO_RST  = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_ONE_RST   = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_TWO_RST   = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_THREE_RST = 64'h1000_0000_0000_0000;

    localparam logic [ROW_SUM_W-1:0] ROW_SUM_ONE = ROW_SUM_W'(1) << FRAC_W;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic                      func;
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
        logic signed [COORD_W-1:0] z_in;
    } in_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic signed [COORD_W-1:0] z_out;
        logic                      w_was_zero;
        logic                      saturated;
    } out_rsp_t;

    typedef struct packed {
        logic [NUM_LANES-1:0] neg;
        logic                 wzero;
    } div_side_t;

endpackage
`default_nettype wire

FILE: hdl/homogeneous_point_vector_transform_core.sv
// Top level: 4x4 homogeneous transform of a point or direction vector.
//
// Channels: in_valid/in_stall/in_data carries one request (mode and x, y, z in Q16.16);
// out_valid/out_stall/out_data returns one result per request in order.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes one 64-bit matrix row; always ready,
// indices 0..3 select rows zero..three. Rows must be written only while the core is empty;
// the core does not enforce this. Pipeline: two multiply/sum stages, one setup stage,
// 54 divider stages of one quotient bit each, one clamp/output stage.
// Throughput: one request per cycle while the output is not stalled; every stage is a register with a valid bit.
// Vector mode and a point whose w is 1.0 go through the divider with divisor 1.0.
// Reset: matrix returns to identity, all valid bits clear, no result pending.
// Stall: while a result is held on a stalled output, the whole pipe freezes
// and in_stall is raised; nothing is dropped or repeated.
`default_nettype none
module homogeneous_point_vector_transform_core
    import hpvt_pkg::*;
#(
    parameter int COEFF_WIDTH = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_stall,
    input  wire in_req_t              in_data,
    output      logic                 out_valid,
    input  wire logic                 out_stall,
    output      out_rsp_t             out_data,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_data
);

    logic [ROW_W-1:0] row0_reg, row1_reg, row2_reg, row3_reg;
    logic en;

    logic vld_a_reg, vld_b_reg, vld_c_reg;
    logic func_a_reg, func_b_reg;
    logic signed [ROW_SUM_W-1:0] r0, r1, r2, r3;

    logic [ROW_SUM_W-1:0] num_reg [NUM_LANES];
    logic [ROW_SUM_W-1:0] den_reg;
    div_side_t            side_reg;
    logic [ROW_SUM_W-1:0] num_next [NUM_LANES];
    logic [ROW_SUM_W-1:0] den_next;
    div_side_t            side_next;

    logic                 dv_vld;
    div_side_t            dv_side;
    logic [QUO_W-1:0]     dv_quo [NUM_LANES];

    logic                      out_valid_reg;
    out_rsp_t                  out_data_reg;
    out_rsp_t                  out_data_next;
    logic signed [COORD_W-1:0] lane_val [NUM_LANES];
    logic [NUM_LANES-1:0]      lane_sat;

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= ROW_ZERO_RST;
            row1_reg <= ROW_ONE_RST;
            row2_reg <= ROW_TWO_RST;
            row3_reg <= ROW_THREE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW_ZERO:  row0_reg <= cfg_data;
                REG_ROW_ONE:   row1_reg <= cfg_data;
                REG_ROW_TWO:   row2_reg <= cfg_data;
                REG_ROW_THREE: row3_reg <= cfg_data;
            endcase
        end
    end

    hpvt_row_mac #(.COEFF_WIDTH(COEFF_WIDTH)) u_mac0 (
        .clk(clk), .en(en), .row(row0_reg), .x(in_data.x_in), .y(in_data.y_in),
        .z(in_data.z_in), .homog(!in_data.func), .row_sum(r0)
    );
    hpvt_row_mac #(.COEFF_WIDTH(COEFF_WIDTH)) u_mac1 (
        .clk(clk), .en(en), .row(row1_reg), .x(in_data.x_in), .y(in_data.y_in),
        .z(in_data.z_in), .homog(!in_data.func), .row_sum(r1)
    );
    hpvt_row_mac #(.COEFF_WIDTH(COEFF_WIDTH)) u_mac2 (
        .clk(clk), .en(en), .row(row2_reg), .x(in_data.x_in), .y(in_data.y_in),
        .z(in_data.z_in), .homog(!in_data.func), .row_sum(r2)
    );
    hpvt_row_mac #(.COEFF_WIDTH(COEFF_WIDTH)) u_mac3 (
        .clk(clk), .en(en), .row(row3_reg), .x(in_data.x_in), .y(in_data.y_in),
        .z(in_data.z_in), .homog(!in_data.func), .row_sum(r3)
    );

    // Setup: magnitudes and signs; vector mode and zero w divide by 1.0.
    always_comb
    begin
        logic wz;
        logic wneg;
        wz   = !func_b_reg && (r3 == '0);
        wneg = !func_b_reg && r3[ROW_SUM_W-1];
        num_next[0] = wz ? '0 : (r0[ROW_SUM_W-1] ? ROW_SUM_W'(-r0) : ROW_SUM_W'(r0));
        num_next[1] = wz ? '0 : (r1[ROW_SUM_W-1] ? ROW_SUM_W'(-r1) : ROW_SUM_W'(r1));
        num_next[2] = wz ? '0 : (r2[ROW_SUM_W-1] ? ROW_SUM_W'(-r2) : ROW_SUM_W'(r2));
        if (func_b_reg || wz)
        begin
            den_next = ROW_SUM_ONE;
        end
        else
        begin
            den_next = wneg ? ROW_SUM_W'(-r3) : ROW_SUM_W'(r3);
        end
        side_next.wzero  = wz;
        side_next.neg[0] = r0[ROW_SUM_W-1] ^ wneg;
        side_next.neg[1] = r1[ROW_SUM_W-1] ^ wneg;
        side_next.neg[2] = r2[ROW_SUM_W-1] ^ wneg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func_a_reg <= in_data.func;
            func_b_reg <= func_a_reg;
            num_reg    <= num_next;
            den_reg    <= den_next;
            side_reg   <= side_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            vld_c_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg     <= in_valid;
            vld_b_reg     <= vld_a_reg;
            vld_c_reg     <= vld_b_reg;
            out_valid_reg <= dv_vld;
        end
    end

    hpvt_div_pipe u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld_c_reg), .in_side(side_reg),
        .num(num_reg), .den(den_reg), .out_vld(dv_vld), .out_side(dv_side), .quo(dv_quo)
    );

    // Apply sign and clamp to coordinate range.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            logic hi_nz;
            logic top;
            logic lo_nz;
            hi_nz = |dv_quo[l][QUO_W-1:COORD_W];
            top   = dv_quo[l][COORD_W-1];
            lo_nz = |dv_quo[l][COORD_W-2:0];
            if (!dv_side.neg[l])
            begin
                lane_sat[l] = hi_nz || top;
                lane_val[l] = lane_sat[l] ? COORD_MAX : $signed(dv_quo[l][COORD_W-1:0]);
            end
            else
            begin
                lane_sat[l] = hi_nz || (top && lo_nz);
                lane_val[l] = lane_sat[l] ? COORD_MIN
                                          : $signed((~dv_quo[l][COORD_W-1:0]) + 1'b1);
            end
        end
        out_data_next.x_out      = lane_val[0];
        out_data_next.y_out      = lane_val[1];
        out_data_next.z_out      = lane_val[2];
        out_data_next.w_was_zero = dv_side.wzero;
        out_data_next.saturated  = |lane_sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_wzero_clears : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.w_was_zero |->
            out_data_reg.x_out == '0 && out_data_reg.y_out == '0 &&
            out_data_reg.z_out == '0 && !out_data_reg.saturated)
        else $error("zero w result not cleared");

    a_sat_at_rail : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.saturated |->
            out_data_reg.x_out == COORD_MAX || out_data_reg.x_out == COORD_MIN ||
            out_data_reg.y_out == COORD_MAX || out_data_reg.y_out == COORD_MIN ||
            out_data_reg.z_out == COORD_MAX || out_data_reg.z_out == COORD_MIN)
        else $error("saturation flag without clamped lane");

    a_setup_advance : assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_b_reg |=> vld_c_reg)
        else $error("setup stage lost a request");

endmodule
`default_nettype wire

FILE: hdl/hpvt_row_mac.sv
// One matrix row: four products, then rounded sum, two register stages.
`default_nettype none
module hpvt_row_mac
    import hpvt_pkg::*;
#(
    parameter int COEFF_WIDTH = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [ROW_W-1:0]            row,
    input  wire logic signed [COORD_W-1:0]   x,
    input  wire logic signed [COORD_W-1:0]   y,
    input  wire logic signed [COORD_W-1:0]   z,
    input  wire logic                        homog,
    output      logic signed [ROW_SUM_W-1:0] row_sum
);

    localparam int COEFF_FRAC = COEFF_WIDTH - 4;
    localparam int PROD_W     = COORD_W + COEFF_WIDTH;
    localparam int SUM_W      = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) << (COEFF_FRAC - 1);

    logic signed [COEFF_WIDTH-1:0] c0, c1, c2, c3;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PROD_W-1:0] p0_next, p1_next, p2_next, p3_next;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_shr;
    logic signed [ROW_SUM_W-1:0] row_sum_reg;

    assign c0 = $signed(row[0*SLOT_W +: COEFF_WIDTH]);
    assign c1 = $signed(row[1*SLOT_W +: COEFF_WIDTH]);
    assign c2 = $signed(row[2*SLOT_W +: COEFF_WIDTH]);
    assign c3 = $signed(row[3*SLOT_W +: COEFF_WIDTH]);

    always_comb
    begin
        p0_next = PROD_W'(c0) * PROD_W'(x);
        p1_next = PROD_W'(c1) * PROD_W'(y);
        p2_next = PROD_W'(c2) * PROD_W'(z);
        p3_next = homog ? (PROD_W'(c3) <<< FRAC_W) : '0;
    end

    always_comb
    begin
        sum = SUM_W'(p0_reg) + SUM_W'(p1_reg) + SUM_W'(p2_reg) + SUM_W'(p3_reg) + RND;
        sum_shr = sum >>> COEFF_FRAC;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg      <= p0_next;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            p3_reg      <= p3_next;
            row_sum_reg <= sum_shr[ROW_SUM_W-1:0];
        end
    end

    assign row_sum = row_sum_reg;

endmodule
`default_nettype wire

FILE: hdl/hpvt_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing a divisor.
`default_nettype none
module hpvt_div_pipe
    import hpvt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire div_side_t            in_side,
    input  wire logic [ROW_SUM_W-1:0] num [NUM_LANES],
    input  wire logic [ROW_SUM_W-1:0] den,
    output      logic                 out_vld,
    output      div_side_t            out_side,
    output      logic [QUO_W-1:0]     quo [NUM_LANES]
);

    logic [ROW_SUM_W-1:0] rem_reg [QUO_W][NUM_LANES];
    logic [QUO_W-1:0]     sh_reg  [QUO_W][NUM_LANES];
    logic [ROW_SUM_W-1:0] den_reg [QUO_W];
    div_side_t            side_reg [QUO_W];
    logic [QUO_W-1:0]     vld_reg;

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        logic [ROW_SUM_W-1:0] den_in;
        div_side_t            side_in;
        logic                 vld_in;

        if (s == 0)
        begin : g_first
            assign den_in  = den;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end
        else
        begin : g_rest
            assign den_in  = den_reg[s-1];
            assign side_in = side_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        for (genvar l = 0; l < NUM_LANES; l++)
        begin : g_lane
            logic [ROW_SUM_W-1:0] rem_in;
            logic [QUO_W-1:0]     sh_in;
            logic [ROW_SUM_W:0]   trial;
            logic                 ge;
            logic [ROW_SUM_W-1:0] rem_next;
            logic [QUO_W-1:0]     sh_next;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign sh_in  = {num[l], {FRAC_W{1'b0}}};
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1][l];
                assign sh_in  = sh_reg[s-1][l];
            end

            always_comb
            begin
                trial    = {rem_in, sh_in[QUO_W-1]};
                ge       = trial >= {1'b0, den_in};
                rem_next = ge ? ROW_SUM_W'(trial - {1'b0, den_in}) : trial[ROW_SUM_W-1:0];
                sh_next  = {sh_in[QUO_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s][l] <= rem_next;
                    sh_reg[s][l]  <= sh_next;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign out_side = side_reg[QUO_W-1];

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_out
        assign quo[l] = sh_reg[QUO_W-1][l];
    end

endmodule
`default_nettype wire
